// ===== sv/piw_pkg.sv =====
// Shared types, constants and table functions for the pose interpolation weights unit.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package piw_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 2;
    localparam int EXP_STEPS     = 16;

    localparam logic [16:0] WEIGHT_ONE   = 17'h10000;
    localparam logic [30:0] EXP_NEG1_Q30 = 31'd395007542;
    localparam logic [30:0] Q30_ONE      = 31'h4000_0000;

    typedef enum logic [2:0] {
        CFG_MODE       = 3'd0,
        CFG_NEAR_DIST  = 3'd1,
        CFG_DIST_CAP   = 3'd2,
        CFG_NEAR_DTIME = 3'd3,
        CFG_DTIME_CAP  = 3'd4,
        CFG_SIGMA      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_LIN_POSE   = 2'd0,
        MODE_LIN_TIME   = 2'd1,
        MODE_GAUSS_POSE = 2'd2,
        MODE_GAUSS_TIME = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ACC
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQRT,
        B_DECIDE,
        B_LDIV,
        B_GSQ,
        B_GDIV,
        B_EXP,
        B_DONE
    } t_back_state;

    typedef struct packed {
        logic signed [31:0] point_coord;
        logic signed [31:0] start_coord;
        logic signed [31:0] end_coord;
        logic signed [31:0] point_ts;
        logic signed [31:0] start_ts;
        logic signed [31:0] end_ts;
        logic               has_start;
        logic               last_axis;
    } t_in_item;

    typedef struct packed {
        logic [16:0] weight_start;
        logic [16:0] weight_end;
        logic        clipped;
    } t_out_item;

    typedef struct packed {
        t_mode       mode;
        logic [30:0] near_dist;
        logic [30:0] dist_cap;
        logic [30:0] near_dtime;
        logic [30:0] dtime_cap;
        logic [30:0] sigma;
    } t_cfg;

    // one finished query handed from front to back
    typedef struct packed {
        logic        has_start;
        logic [63:0] ss;
        logic [63:0] se;
        logic [31:0] point_ts;
        logic [31:0] start_ts;
        logic [31:0] end_ts;
    } t_job;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [33:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    typedef logic [EXP_STEPS:0][30:0] t_exp_tab;

    function automatic logic [31:0] abs_diff32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? (33'd0 - d) : d;
        return m[31:0];
    endfunction

    // elaboration-time integer square root
    function automatic logic [63:0] isqrt_f(input logic [63:0] n);
        logic [65:0] rem;
        logic [65:0] trial;
        logic [63:0] root;
        rem  = '0;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            rem   = {rem[63:0], n[2*i +: 2]};
            trial = {root, 2'b01};
            if (rem >= trial) begin
                rem  = rem - trial;
                root = {root[62:0], 1'b1};
            end else begin
                root = {root[62:0], 1'b0};
            end
        end
        return root;
    endfunction

    // e^-1 and successive square roots, Q30
    function automatic t_exp_tab exp_tab_f();
        t_exp_tab    tab;
        logic [63:0] r;
        tab[0] = EXP_NEG1_Q30;
        for (int k = 1; k <= EXP_STEPS; k++) begin
            r      = isqrt_f({3'b000, tab[k-1], 30'd0});
            tab[k] = r[30:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = exp_tab_f();

endpackage

`default_nettype wire

// ===== sv/piw_front.sv =====
// Front end: accepts axis beats, squares the differences and accumulates the sums.
// Pushes one job per query into the queue. Depends on piw_pkg.
`default_nettype none

module piw_front (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output                     logic o_in_ready,
    input  wire piw_pkg::t_in_item i_in,
    input  wire                logic i_q_full,
    output                     logic o_push,
    output piw_pkg::t_job            o_job
);
    import piw_pkg::*;

    t_front_state r_state, n_state;
    logic [31:0]  r_a, r_b;
    logic [63:0]  r_pa, r_pb;
    logic [63:0]  r_ss, r_se;
    logic         r_has_start, r_last;
    logic [31:0]  r_pt, r_st, r_et;
    logic [64:0]  w_ss_sum, w_se_sum;
    logic [63:0]  w_ss, w_se;

    assign w_ss_sum = {1'b0, r_ss} + {1'b0, r_pa};
    assign w_se_sum = {1'b0, r_se} + {1'b0, r_pb};
    assign w_ss     = w_ss_sum[64] ? '1 : w_ss_sum[63:0];
    assign w_se     = w_se_sum[64] ? '1 : w_se_sum[63:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_in_valid) n_state = F_MUL;
            F_MUL:  n_state = F_ACC;
            F_ACC:  if (!r_last || !i_q_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == F_IDLE);
        o_push     = (r_state == F_ACC) && r_last && !i_q_full;
    end

    always_comb begin
        o_job.has_start = r_has_start;
        o_job.ss        = w_ss;
        o_job.se        = w_se;
        o_job.point_ts  = r_pt;
        o_job.start_ts  = r_st;
        o_job.end_ts    = r_et;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_ss    <= '0;
            r_se    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == F_ACC) begin
                if (!r_last) begin
                    r_ss <= w_ss;
                    r_se <= w_se;
                end else if (!i_q_full) begin
                    r_ss <= '0;
                    r_se <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_a         <= abs_diff32(i_in.point_coord, i_in.start_coord);
            r_b         <= abs_diff32(i_in.end_coord, i_in.point_coord);
            r_has_start <= i_in.has_start;
            r_last      <= i_in.last_axis;
            r_pt        <= i_in.point_ts;
            r_st        <= i_in.start_ts;
            r_et        <= i_in.end_ts;
        end
        if (r_state == F_MUL) begin
            r_pa <= r_a * r_a;
            r_pb <= r_b * r_b;
        end
    end

endmodule

`default_nettype wire

// ===== sv/piw_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on piw_pkg for the job type and depth.
`default_nettype none

module piw_queue (
    input  wire           logic i_clk,
    input  wire           logic i_rst_n,
    input  wire           logic i_push,
    input  wire piw_pkg::t_job  i_job,
    input  wire           logic i_pop,
    output piw_pkg::t_job       o_head,
    output                logic o_full,
    output                logic o_empty
);
    import piw_pkg::*;

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_job            r_mem [QDEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/piw_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the back end.
// Depends on piw_pkg for the request and response structs.
`default_nettype none

module piw_div (
    input  wire               logic i_clk,
    input  wire               logic i_rst_n,
    input  wire piw_pkg::t_div_req  i_req,
    output piw_pkg::t_div_rsp       o_rsp
);
    import piw_pkg::*;

    localparam int NUM_W = 64;
    localparam int DEN_W = 34;
    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [DEN_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_quot[NUM_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_quot <= i_req.num;
            r_den  <= i_req.den;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? DEN_W'(w_sh - {1'b0, r_den}) : w_sh[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// ===== sv/piw_back.sv =====
// Back end: square roots, linear and gaussian weights, output register.
// Depends on piw_pkg; drives the shared piw_div through a request struct.
`default_nettype none

module piw_back #(
    parameter int FRAC_BITS = piw_pkg::FRAC_BITS_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire piw_pkg::t_cfg       i_cfg,
    input  wire                logic i_q_empty,
    input  wire piw_pkg::t_job       i_job,
    output                     logic o_pop,
    output piw_pkg::t_div_req        o_div_req,
    input  wire piw_pkg::t_div_rsp   i_div_rsp,
    output                     logic o_out_valid,
    input  wire                logic i_out_ready,
    output piw_pkg::t_out_item       o_out
);
    import piw_pkg::*;

    localparam int          SQ_STEPS  = 32;
    localparam logic [4:0]  SQ_LAST   = 5'(SQ_STEPS - 1);
    localparam logic [4:0]  K_END     = 5'(EXP_STEPS + 1);
    localparam logic [63:0] EXP_LIMIT = 64'(12) << FRAC_BITS;
    localparam int          XSH_R     = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int          XSH_L     = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    t_back_state r_state, n_state;
    t_job        r_job;
    logic        r_side;
    logic [63:0] r_sq_num;
    logic [33:0] r_sq_rem;
    logic [31:0] r_sq_root;
    logic [4:0]  r_cnt;
    logic [31:0] r_d1, r_d2;
    logic [47:0] r_num0, r_num1;
    logic [33:0] r_den;
    logic        r_div_sent;
    logic [63:0] r_gval;
    logic [30:0] r_acc;
    logic [15:0] r_xfrac;
    logic [3:0]  r_exp_n;
    logic [4:0]  r_exp_k;
    logic [16:0] r_ws, r_we;
    logic        r_clip;
    logic        r_out_valid;
    t_out_item   r_out;

    // sqrt step
    logic [35:0] w_sq_t, w_sq_trial;
    logic        w_sq_ge;
    // decision
    logic [32:0] w_t1, w_t2;
    logic [33:0] w_s1, w_s2, w_near, w_max, w_d_one, w_total;
    logic        w_snap1, w_snap2, w_one_near, w_one_lt;
    // shared multiplier
    logic [31:0] w_mul_a, w_mul_b, w_g;
    logic [63:0] w_prod;
    logic [30:0] w_factor;
    logic [4:0]  w_k_idx;
    logic [31:0] w_round;
    logic [63:0] w_x16_full;
    logic        w_exp_end, w_out_free, w_div_done;

    assign w_sq_t     = {r_sq_rem, r_sq_num[63:62]};
    assign w_sq_trial = {2'b00, r_sq_root, 2'b01};
    assign w_sq_ge    = (w_sq_t >= w_sq_trial);

    assign w_t1 = {r_job.point_ts[31], r_job.point_ts}
                - {r_job.start_ts[31], r_job.start_ts};
    assign w_t2 = {r_job.end_ts[31], r_job.end_ts}
                - {r_job.point_ts[31], r_job.point_ts};

    always_comb begin
        if (i_cfg.mode == MODE_LIN_TIME) begin
            w_s1    = {w_t1[32], w_t1};
            w_s2    = {w_t2[32], w_t2};
            w_near  = {3'b000, i_cfg.near_dtime};
            w_max   = {3'b000, i_cfg.dtime_cap};
            w_d_one = {2'b00, abs_diff32(r_job.point_ts, r_job.end_ts)};
        end else begin
            w_s1    = {2'b00, r_d1};
            w_s2    = {2'b00, r_d2};
            w_near  = {3'b000, i_cfg.near_dist};
            w_max   = {3'b000, i_cfg.dist_cap};
            w_d_one = {2'b00, r_d2};
        end
    end

    assign w_snap1    = ($signed(w_s1) <= $signed(w_near));
    assign w_snap2    = ($signed(w_s2) <= $signed(w_near));
    assign w_one_near = (w_d_one <= w_near);
    assign w_one_lt   = (w_d_one < w_max);
    assign w_total    = w_s1 + w_s2;

    assign w_g = r_side ? abs_diff32(r_job.end_ts, r_job.point_ts)
                        : abs_diff32(r_job.point_ts, r_job.start_ts);
    assign w_k_idx  = (r_exp_k > 5'(EXP_STEPS)) ? 5'(EXP_STEPS) : r_exp_k;
    assign w_factor = (r_exp_n != '0) ? EXP_TAB[0]
                    : (r_xfrac[15] ? EXP_TAB[w_k_idx] : Q30_ONE);

    always_comb begin
        if (r_state == B_GSQ) begin
            w_mul_a = w_g;
            w_mul_b = w_g;
        end else begin
            w_mul_a = {1'b0, r_acc};
            w_mul_b = {1'b0, w_factor};
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    assign w_exp_end  = (r_exp_n == '0) && (r_exp_k == K_END);
    assign w_round    = {1'b0, r_acc} + 32'h2000;
    assign w_x16_full = (i_div_rsp.quot >> XSH_R) << XSH_L;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_div_done = r_div_sent && i_div_rsp.done;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cfg.mode)
                        MODE_LIN_POSE: n_state = B_SQRT;
                        MODE_LIN_TIME: n_state = B_DECIDE;
                        default:       n_state = B_GSQ;
                    endcase
                end
            end
            B_SQRT: if (r_cnt == SQ_LAST && r_side) n_state = B_DECIDE;
            B_DECIDE: begin
                if (!r_job.has_start) begin
                    n_state = (!w_one_near && w_one_lt) ? B_LDIV : B_DONE;
                end else begin
                    n_state = (w_snap1 || w_snap2) ? B_DONE : B_LDIV;
                end
            end
            B_LDIV: if (w_div_done && r_side) n_state = B_DONE;
            B_GSQ:  n_state = B_GDIV;
            B_GDIV: begin
                if (w_div_done) begin
                    if (i_div_rsp.quot < EXP_LIMIT) n_state = B_EXP;
                    else n_state = r_side ? B_DONE : B_GSQ;
                end
            end
            B_EXP:  if (w_exp_end) n_state = r_side ? B_DONE : B_GSQ;
            B_DONE: if (w_out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop           = (r_state == B_IDLE) && !i_q_empty;
        o_div_req.start = ((r_state == B_LDIV) || (r_state == B_GDIV)) && !r_div_sent;
        if (r_state == B_GDIV) begin
            o_div_req.num = r_gval;
            o_div_req.den = (i_cfg.sigma == '0) ? 34'd2 : {2'b00, i_cfg.sigma, 1'b0};
        end else begin
            o_div_req.num = {16'd0, (r_side ? r_num1 : r_num0)};
            o_div_req.den = r_den;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_div_sent  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_div_req.start) begin
                r_div_sent <= 1'b1;
            end else if (w_div_done) begin
                r_div_sent <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job     <= i_job;
                r_ws      <= '0;
                r_we      <= '0;
                r_clip    <= 1'b0;
                r_side    <= (i_cfg.mode == MODE_GAUSS_POSE || i_cfg.mode == MODE_GAUSS_TIME)
                             ? !i_job.has_start : 1'b0;
                r_sq_num  <= i_job.ss;
                r_sq_rem  <= '0;
                r_sq_root <= '0;
                r_cnt     <= '0;
            end
            B_SQRT: begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SQ_LAST) begin
                    if (!r_side) begin
                        r_d1      <= w_sq_ge ? {r_sq_root[30:0], 1'b1} : {r_sq_root[30:0], 1'b0};
                        r_side    <= 1'b1;
                        r_sq_num  <= r_job.se;
                        r_sq_rem  <= '0;
                        r_sq_root <= '0;
                    end else begin
                        r_d2 <= w_sq_ge ? {r_sq_root[30:0], 1'b1} : {r_sq_root[30:0], 1'b0};
                    end
                end else begin
                    r_sq_num  <= {r_sq_num[61:0], 2'b00};
                    r_sq_rem  <= w_sq_ge ? 34'(w_sq_t - w_sq_trial) : w_sq_t[33:0];
                    r_sq_root <= {r_sq_root[30:0], w_sq_ge};
                end
            end
            B_DECIDE: begin
                if (!r_job.has_start) begin
                    r_side <= 1'b1;
                    r_num1 <= {(w_max[30:0] - w_d_one[30:0]), 17'd0} >> 1;
                    r_den  <= w_max;
                    if (w_one_near) begin
                        r_we <= WEIGHT_ONE;
                    end else if (!w_one_lt) begin
                        r_clip <= (w_d_one > w_max);
                    end
                end else begin
                    r_side <= 1'b0;
                    r_num0 <= {w_s2[31:0], 16'd0};
                    r_num1 <= {w_s1[31:0], 16'd0};
                    r_den  <= w_total;
                    if (w_snap1) begin
                        r_ws <= WEIGHT_ONE;
                    end else if (w_snap2) begin
                        r_we <= WEIGHT_ONE;
                    end
                end
            end
            B_LDIV: begin
                if (w_div_done) begin
                    if (!r_side) begin
                        r_ws   <= i_div_rsp.quot[16:0];
                        r_side <= 1'b1;
                    end else begin
                        r_we <= i_div_rsp.quot[16:0];
                    end
                end
            end
            B_GSQ: begin
                if (i_cfg.mode == MODE_GAUSS_TIME) begin
                    r_gval <= w_prod;
                end else begin
                    r_gval <= r_side ? r_job.se : r_job.ss;
                end
            end
            B_GDIV: begin
                if (w_div_done) begin
                    r_acc   <= Q30_ONE;
                    r_exp_n <= w_x16_full[19:16];
                    r_xfrac <= w_x16_full[15:0];
                    r_exp_k <= 5'd1;
                    if (i_div_rsp.quot >= EXP_LIMIT) begin
                        r_side <= 1'b1;
                    end
                end
            end
            B_EXP: begin
                if (w_exp_end) begin
                    if (!r_side) begin
                        r_ws   <= w_round[30:14];
                        r_side <= 1'b1;
                    end else begin
                        r_we <= w_round[30:14];
                    end
                end else begin
                    r_acc <= w_prod[60:30];
                    if (r_exp_n != '0) begin
                        r_exp_n <= r_exp_n - 1'b1;
                    end else begin
                        r_exp_k <= r_exp_k + 1'b1;
                        r_xfrac <= {r_xfrac[14:0], 1'b0};
                    end
                end
            end
            B_DONE: begin
                if (w_out_free) begin
                    r_out.weight_start <= r_ws;
                    r_out.weight_end   <= r_we;
                    r_out.clipped      <= r_clip;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/pose_interpolation_weights_unit.sv =====
// Pose interpolation weights, top level: configuration registers, front end,
// job queue, shared divider and back end. Depends on piw_pkg and all piw_* modules.
//
// Input channel: one beat per axis of a query (query, start and end pose
// components plus timestamps); the beat with last_axis set closes the query.
// Output channel: one beat per query carrying weight_start, weight_end (Q1.16,
// 0x10000 is one) and the clipped flag.
// Flow: the front end accepts an axis beat only while idle and passes it through
// register, square and saturating accumulate steps; a closing beat waits in the
// accumulate step while the queue is full. The back end takes one query at a time:
// linear pose mode runs two 32-bit square roots and up to two 64-bit divisions;
// linear time mode up to two divisions; gaussian modes per side one square (time
// mode only), one 64-bit division and up to 27 exponent multiply steps. The
// shared divider does most of that work. A two-entry queue lets the front keep
// accepting axis beats of the next queries while the back end works; results wait
// in an output register, and when the receiver stalls the back end holds, then
// the queue fills, then the input stalls. Reset clears the sums, queue, output
// valid and sets the register defaults. Configuration writes take effect at once;
// the user must make them only while idle, as the block does not enforce this.
`default_nettype none

module pose_interpolation_weights_unit #(
    parameter int FRAC_BITS = piw_pkg::FRAC_BITS_DEF
) (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_in_valid,
    output                     logic o_in_ready,
    input  wire piw_pkg::t_in_item   i_in,
    output                     logic o_out_valid,
    input  wire                logic i_out_ready,
    output piw_pkg::t_out_item       o_out,
    input  wire                logic i_cfg_we,
    input  wire         logic [2:0]  i_cfg_index,
    input  wire         logic [30:0] i_cfg_wdata
);
    import piw_pkg::*;

    t_cfg      r_cfg;
    logic      w_push, w_pop, w_q_full, w_q_empty;
    t_job      w_front_job, w_head;
    t_div_req  w_div_req;
    t_div_rsp  w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode       <= MODE_LIN_POSE;
            r_cfg.near_dist  <= '0;
            r_cfg.dist_cap   <= 31'd65536;
            r_cfg.near_dtime <= '0;
            r_cfg.dtime_cap  <= 31'd65536;
            r_cfg.sigma      <= 31'd65536;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:       r_cfg.mode       <= t_mode'(i_cfg_wdata[1:0]);
                CFG_NEAR_DIST:  r_cfg.near_dist  <= i_cfg_wdata;
                CFG_DIST_CAP:   r_cfg.dist_cap   <= i_cfg_wdata;
                CFG_NEAR_DTIME: r_cfg.near_dtime <= i_cfg_wdata;
                CFG_DTIME_CAP:  r_cfg.dtime_cap  <= i_cfg_wdata;
                CFG_SIGMA:      r_cfg.sigma      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    piw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    piw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    piw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    piw_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_empty   (w_q_empty),
        .i_job       (w_head),
        .o_pop       (w_pop),
        .o_div_req   (w_div_req),
        .i_div_rsp   (w_div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("job pushed into a full queue");

    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.weight_start <= 17'h10000) && (o_out.weight_end <= 17'h10000))
        else $error("weight above one");

    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.clipped |-> (o_out.weight_end == '0) && (o_out.weight_start == '0))
        else $error("clipped result with a nonzero weight");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat right after reset");
`endif

endmodule

`default_nettype wire
